>>> sv/video_register_port_and_vram_access_macros.svh
// ---------------------------------------------------------------------------
// Video register port assertion macros
// Shared assertion wrappers for the video register port design.
// ---------------------------------------------------------------------------
`ifndef VIDEO_REGISTER_PORT_AND_VRAM_ACCESS_MACROS_SVH
`define VIDEO_REGISTER_PORT_AND_VRAM_ACCESS_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define VRP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define VRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> sv/vrp_pkg.sv
// ---------------------------------------------------------------------------
// Video register port package
// Request codes, register numbers and memory map constants.
// ---------------------------------------------------------------------------
package vrp_pkg;
	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;
	localparam logic [1:0] REQ_NOP   = 2'd3;

	localparam logic [2:0] REG_CTRL   = 3'd0;
	localparam logic [2:0] REG_MASK   = 3'd1;
	localparam logic [2:0] REG_STATUS = 3'd2;
	localparam logic [2:0] REG_OAMA   = 3'd3;
	localparam logic [2:0] REG_OAMD   = 3'd4;
	localparam logic [2:0] REG_SCROLL = 3'd5;
	localparam logic [2:0] REG_ADDR   = 3'd6;
	localparam logic [2:0] REG_DATA   = 3'd7;

	localparam logic [1:0] MIR_VERT  = 2'd0;
	localparam logic [1:0] MIR_HORZ  = 2'd1;

	localparam logic [13:0] PAL_BASE = 14'h3F00;
	localparam logic [8:0]  DOT_LAST = 9'd340;
	localparam logic [9:0]  LINE_PRE = 10'h3FF;
	localparam logic [9:0]  LINE_VBL = 10'd241;
	localparam logic [9:0]  LINE_LAST = 10'd260;

	localparam logic [1:0] TGT_PAT = 2'd0;
	localparam logic [1:0] TGT_NT  = 2'd1;
	localparam logic [1:0] TGT_PAL = 2'd2;

	typedef struct packed {
		logic       we;
		logic [1:0] tgt;
		logic [12:0] pat_idx;
		logic [11:0] nt_idx;
		logic [4:0] pal_idx;
		logic [7:0] wdata;
	} vmem_req_t;

	function automatic logic [4:0] pal_index(input logic [13:0] a);
		logic [4:0] p;
		p = a[4:0];
		if ((a[4:0] & 5'h13) == 5'h10) p[4] = 1'b0;
		return p;
	endfunction
endpackage

>>> sv/vrp_vmem.sv
// ---------------------------------------------------------------------------
// Video memory
// Pattern, nametable and palette stores with registered read data.
// ---------------------------------------------------------------------------
module vrp_vmem
	import vrp_pkg::*;
#(
	parameter int NAMETABLE_BYTES = 4096,
	parameter int PATTERN_BYTES = 8192
) (
	input  logic      clk,
	input  logic      en,
	input  vmem_req_t req,
	output logic [7:0] rdata
);
	localparam int NTW = $clog2(NAMETABLE_BYTES);
	localparam int PTW = $clog2(PATTERN_BYTES);

	logic [7:0] pat_mem [PATTERN_BYTES];
	logic [7:0] nt_mem [NAMETABLE_BYTES];
	logic [7:0] pal_mem [32];
	logic [7:0] pat_q, nt_q, pal_q;
	logic [1:0] tgt_q;

	always_ff @(posedge clk) begin
		if (en && req.we && req.tgt == TGT_PAT) pat_mem[req.pat_idx[PTW-1:0]] <= req.wdata;
		pat_q <= pat_mem[req.pat_idx[PTW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (en && req.we && req.tgt == TGT_NT) nt_mem[req.nt_idx[NTW-1:0]] <= req.wdata;
		nt_q <= nt_mem[req.nt_idx[NTW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (en && req.we && req.tgt == TGT_PAL) pal_mem[req.pal_idx] <= req.wdata;
		pal_q <= pal_mem[req.pal_idx];
		tgt_q <= req.tgt;
	end

	always_comb begin
		case (tgt_q)
			TGT_PAT: rdata = pat_q;
			TGT_NT:  rdata = nt_q;
			default: rdata = pal_q;
		endcase
	end
endmodule

>>> sv/vrp_timer.sv
// ---------------------------------------------------------------------------
// Dot and scanline timer
// Counts dots and scanlines and flags the vblank start and end points.
// ---------------------------------------------------------------------------
module vrp_timer
	import vrp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic tick,
	output logic vbl_set,
	output logic vbl_clr
);
	logic [8:0] dot_q;
	logic [9:0] line_q;
	logic [8:0] dot_eff;

	always_comb begin
		dot_eff = (line_q == 10'd0 && dot_q == 9'd0) ? 9'd1 : dot_q;
		vbl_set = line_q == LINE_VBL && dot_eff == 9'd1;
		vbl_clr = line_q == LINE_PRE && dot_eff == 9'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			line_q <= '0;
		end else if (tick) begin
			if (dot_eff == DOT_LAST) begin
				dot_q <= '0;
				line_q <= (line_q == LINE_LAST) ? LINE_PRE : line_q + 10'd1;
			end else begin
				dot_q <= dot_eff + 9'd1;
			end
		end
	end
endmodule

>>> sv/video_register_port_and_vram_access.sv
// ---------------------------------------------------------------------------
// Video register port and VRAM access
// CPU register port of a tile video chip with VRAM decode and dot timer.
// ---------------------------------------------------------------------------
// Most requests are answered directly in the result register. A data port read
// or a sprite RAM read first enters a busy state, as memory read data is
// registered after the address. Ticks and all writes are accepted every cycle
// while no read is busy and the result register is free or being drained.
module video_register_port_and_vram_access
	import vrp_pkg::*;
#(
	parameter int NAMETABLE_BYTES = 4096,
	parameter int PATTERN_BYTES = 8192,
	parameter int SPRITE_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // reg_index[2:0], write_data[10:3], zero
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // read_data[7:0], nmi_request[8], in_vblank[9], zero
);
	`include "video_register_port_and_vram_access_macros.svh"

	localparam int SPW = $clog2(SPRITE_BYTES);
	localparam logic [1:0] RD_NONE = 2'd0;
	localparam logic [1:0] RD_OAM  = 2'd1;
	localparam logic [1:0] RD_VRAM = 2'd2;

	logic [1:0] req_type;
	logic [2:0] reg_index;
	logic [7:0] write_data;
	assign req_type = s_tuser;
	assign reg_index = s_tdata[2:0];
	assign write_data = s_tdata[10:3];

	logic [1:0] mir_q;
	logic [7:0] ctrl_q, mask_q, oam_addr_q, rbuf_q;
	logic [2:0] stat_q, fine_x_q;
	logic toggle_q;
	logic [14:0] t_q, v_q;
	logic busy_q;
	logic [1:0] rd_kind_s1;
	logic [7:0] rbuf_old_s1;
	logic pal_s1;
	logic out_v_q;
	logic [7:0] out_rd_q;
	logic out_nmi_q, out_vbl_q;

	logic [7:0] oam_mem [SPRITE_BYTES];
	logic [7:0] oam_rd;
	logic [7:0] vm_rd;
	vmem_req_t vreq;
	logic [13:0] a14;
	logic [11:0] nt_i;

	logic out_free, acc, tick, vbl_set, vbl_clr, is_rd, is_wr, pal_cur;
	logic [7:0] pal_mask;

	assign out_free = !out_v_q || m_tready;
	assign s_tready = !busy_q && out_free;
	assign acc = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign tick = acc && req_type == REQ_TICK;
	assign is_rd = acc && req_type == REQ_READ;
	assign is_wr = acc && req_type == REQ_WRITE;
	assign a14 = v_q[13:0];
	assign pal_cur = a14 >= PAL_BASE;
	assign pal_mask = mask_q[0] ? 8'h30 : 8'hFF;

	always_comb begin
		unique case (mir_q)
			MIR_VERT: nt_i = {1'b0, a14[10:0]};
			MIR_HORZ: nt_i = {1'b0, a14[11], a14[9:0]};
			default:  nt_i = a14[11:0];
		endcase
		vreq.we = is_wr && reg_index == REG_DATA;
		vreq.tgt = (a14 < 14'h2000) ? TGT_PAT : (pal_cur ? TGT_PAL : TGT_NT);
		vreq.pat_idx = a14[12:0];
		vreq.nt_idx = nt_i;
		vreq.pal_idx = pal_index(a14);
		vreq.wdata = write_data;
	end

	vrp_vmem #(.NAMETABLE_BYTES(NAMETABLE_BYTES), .PATTERN_BYTES(PATTERN_BYTES)) u_vmem (
		.clk(clk), .en(acc), .req(vreq), .rdata(vm_rd)
	);

	vrp_timer u_timer (
		.clk(clk), .arst_n(arst_n), .tick(tick), .vbl_set(vbl_set), .vbl_clr(vbl_clr)
	);

	always_ff @(posedge clk) begin
		if (is_wr && reg_index == REG_OAMD) oam_mem[oam_addr_q[SPW-1:0]] <= write_data;
		oam_rd <= oam_mem[oam_addr_q[SPW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mir_q <= '0; ctrl_q <= '0; mask_q <= '0; stat_q <= '0; oam_addr_q <= '0;
			toggle_q <= 1'b0; fine_x_q <= '0; t_q <= '0; v_q <= '0; rbuf_q <= '0;
			busy_q <= 1'b0; rd_kind_s1 <= RD_NONE; rbuf_old_s1 <= '0; pal_s1 <= 1'b0;
			out_v_q <= 1'b0; out_rd_q <= '0; out_nmi_q <= 1'b0; out_vbl_q <= 1'b0;
		end else begin
			if (cfg_valid) mir_q <= cfg_data;
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			if (busy_q) begin
				busy_q <= 1'b0;
				out_v_q <= 1'b1;
				out_nmi_q <= 1'b0;
				out_vbl_q <= stat_q[2];
				if (rd_kind_s1 == RD_OAM) begin
					out_rd_q <= oam_rd;
				end else begin
					rbuf_q <= vm_rd;
					out_rd_q <= pal_s1 ? (vm_rd & pal_mask) : rbuf_old_s1;
					if (pal_s1) rbuf_q <= vm_rd & pal_mask;
				end
			end else if (acc) begin
				out_v_q <= 1'b1;
				out_rd_q <= '0;
				out_nmi_q <= 1'b0;
				out_vbl_q <= stat_q[2];
				case (req_type)
					REQ_READ: begin
						unique case (reg_index)
							REG_STATUS: begin
								out_rd_q <= {stat_q, rbuf_q[4:0]};
								stat_q[2] <= 1'b0;
								out_vbl_q <= 1'b0;
								toggle_q <= 1'b0;
							end
							REG_OAMD: begin
								busy_q <= 1'b1; out_v_q <= 1'b0; rd_kind_s1 <= RD_OAM;
							end
							REG_DATA: begin
								busy_q <= 1'b1; out_v_q <= 1'b0; rd_kind_s1 <= RD_VRAM;
								rbuf_old_s1 <= rbuf_q; pal_s1 <= pal_cur;
								v_q <= v_q + (ctrl_q[2] ? 15'd32 : 15'd1);
							end
							default: ;
						endcase
					end
					REQ_WRITE: begin
						unique case (reg_index)
							REG_CTRL: begin ctrl_q <= write_data; t_q[11:10] <= write_data[1:0]; end
							REG_MASK: mask_q <= write_data;
							REG_OAMA: oam_addr_q <= write_data;
							REG_OAMD: oam_addr_q <= oam_addr_q + 8'd1;
							REG_SCROLL: begin
								toggle_q <= !toggle_q;
								if (!toggle_q) begin
									fine_x_q <= write_data[2:0];
									t_q[4:0] <= write_data[7:3];
								end else begin
									t_q[14:12] <= write_data[2:0];
									t_q[9:5] <= write_data[7:3];
								end
							end
							REG_ADDR: begin
								toggle_q <= !toggle_q;
								if (!toggle_q) t_q[14:8] <= {1'b0, write_data[5:0]};
								else begin
									t_q[7:0] <= write_data;
									v_q <= {t_q[14:8], write_data};
								end
							end
							REG_DATA: v_q <= v_q + (ctrl_q[2] ? 15'd32 : 15'd1);
							default: ;
						endcase
					end
					REQ_TICK: begin
						if (vbl_clr) begin stat_q <= '0; out_vbl_q <= 1'b0; end
						if (vbl_set) begin
							stat_q[2] <= 1'b1; out_vbl_q <= 1'b1; out_nmi_q <= ctrl_q[7];
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {6'd0, out_vbl_q, out_nmi_q, out_rd_q};

	`VRP_ASSERT_NEXT(a_busy_one, clk, arst_n, busy_q, !busy_q && out_v_q)
	`VRP_ASSERT_IMP(a_no_acc_busy, clk, arst_n, busy_q, !s_tready)
	`VRP_ASSERT_IMP(a_nmi_vbl, clk, arst_n, out_v_q && out_nmi_q, out_vbl_q)
	`VRP_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule
